// File: rtl/core/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants and codes for the sorted timer expiry queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_OUT        = 16;
    localparam int OUT_CNT_W      = 5;
    localparam int TIME_W         = 64;
    localparam int ID_FIELD_W     = 4;
    localparam int KIND_W         = 2;
    localparam int IN_DATA_W      = 136;
    localparam int OUT_DATA_W     = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

endpackage

// File: rtl/core/sorted_timer_expiry_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_timer_expiry_queue_unit
// Timer queue kept in expiry order in one RAM of {expiry, id} entries.
// ----------------------------------------------------------------------------
// An add or delete walks the queued entries, reading and then evaluating each;
// an add of a queued timer walks them twice. A tick walks the entries up to the
// first unexpired one when nothing expires, else the full list, and can stall on
// the output. One word is in work at a time. Reset empties the queue at once.
// ----------------------------------------------------------------------------
module sorted_timer_expiry_queue_unit #(
    parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // timer_id [3:0], expiry_ns [67:4], now_ns [131:68], zero pad
    input  logic [stq_pkg::IN_DATA_W-1:0]        s_tdata,
    // kind [1:0]
    input  logic [stq_pkg::KIND_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // expired_id [3:0], zero pad
    output logic [stq_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast
);

    localparam int ID_W  = $clog2(NUM_TIMERS);
    localparam int PW    = $clog2(NUM_TIMERS + 1);
    localparam int ENT_W = stq_pkg::TIME_W + ID_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEL_RD,
        ST_DEL_EV,
        ST_INS_RD,
        ST_INS_EV,
        ST_TCK_RD,
        ST_TCK_EV
    } state_t;

    state_t                           state_reg, state_next;
    logic [PW-1:0]                    cnt_reg, cnt_next;
    logic [PW-1:0]                    pos_reg, pos_next;
    logic [NUM_TIMERS-1:0]            queued_reg, queued_next;
    logic [ID_W-1:0]                  id_reg, id_next;
    logic [stq_pkg::TIME_W-1:0]       t_reg, t_next;
    logic                             add_reg, add_next;
    logic                             found_reg, found_next;
    logic                             ins_reg, ins_next;
    logic [ENT_W-1:0]                 carry_reg, carry_next;
    logic [stq_pkg::OUT_CNT_W-1:0]    n_reg, n_next;
    logic [ID_W-1:0]                  pend_reg, pend_next;
    logic                             ovalid_reg, ovalid_next;
    logic [stq_pkg::ID_FIELD_W-1:0]   oid_reg, oid_next;
    logic                             olast_reg, olast_next;

    logic                             mem_we;
    logic [ID_W-1:0]                  mem_waddr;
    logic [ENT_W-1:0]                 mem_wdata;
    logic                             mem_re;
    logic [ENT_W-1:0]                 mem_rdata;
    logic [ID_W-1:0]                  e_id;
    logic [stq_pkg::TIME_W-1:0]       e_exp;
    logic [stq_pkg::ID_FIELD_W-1:0]   in_id;
    logic                             in_ok;
    logic                             out_free;
    logic [PW-1:0]                    n_pos;
    logic [PW-1:0]                    pos_inc;

    assign e_id     = mem_rdata[ID_W-1:0];
    assign e_exp    = mem_rdata[ENT_W-1:ID_W];
    assign in_id    = s_tdata[3:0];
    assign in_ok    = 32'(in_id) < 32'(NUM_TIMERS);
    assign out_free = !ovalid_reg || m_tready;
    assign n_pos    = PW'(n_reg);
    assign pos_inc  = pos_reg + PW'(1);

    stq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_TIMERS)
    ) u_list (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (pos_reg[ID_W-1:0]),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        queued_next = queued_reg;
        id_next     = id_reg;
        t_next      = t_reg;
        add_next    = add_reg;
        found_next  = found_reg;
        ins_next    = ins_reg;
        carry_next  = carry_reg;
        n_next      = n_reg;
        pend_next   = pend_reg;
        ovalid_next = ovalid_reg && !m_tready;
        oid_next    = oid_reg;
        olast_next  = olast_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg[ID_W-1:0];
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    id_next    = ID_W'(in_id);
                    pos_next   = '0;
                    found_next = 1'b0;
                    ins_next   = 1'b0;
                    n_next     = '0;
                    case (stq_pkg::kind_t'(s_tuser))
                        stq_pkg::KIND_ADD:
                        begin
                            t_next   = s_tdata[67:4];
                            add_next = 1'b1;
                            if (in_ok)
                            begin
                                state_next = queued_reg[ID_W'(in_id)] ? ST_DEL_RD : ST_INS_RD;
                            end
                        end
                        stq_pkg::KIND_DEL:
                        begin
                            add_next = 1'b0;
                            if (in_ok && queued_reg[ID_W'(in_id)])
                            begin
                                state_next = ST_DEL_RD;
                            end
                        end
                        stq_pkg::KIND_TICK:
                        begin
                            t_next = s_tdata[131:68];
                            if (cnt_reg != '0)
                            begin
                                state_next = ST_TCK_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DEL_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_DEL_EV;
            end
            ST_DEL_EV:
            begin
                if (found_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ID_W'(pos_reg - PW'(1));
                end
                else if (e_id == id_reg)
                begin
                    found_next = 1'b1;
                end
                pos_next = pos_inc;
                if (pos_inc == cnt_reg)
                begin
                    cnt_next            = cnt_reg - PW'(1);
                    queued_next[id_reg] = 1'b0;
                    pos_next            = '0;
                    state_next          = add_reg ? ST_INS_RD : ST_IDLE;
                end
                else
                begin
                    state_next = ST_DEL_RD;
                end
            end
            ST_INS_RD:
            begin
                if (pos_reg == cnt_reg)
                begin
                    mem_we              = 1'b1;
                    mem_wdata           = ins_reg ? carry_reg : {t_reg, id_reg};
                    cnt_next            = cnt_reg + PW'(1);
                    queued_next[id_reg] = 1'b1;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_INS_EV;
                end
            end
            ST_INS_EV:
            begin
                carry_next = mem_rdata;
                if (ins_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = carry_reg;
                end
                else if (e_exp > t_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = {t_reg, id_reg};
                    ins_next  = 1'b1;
                end
                pos_next   = pos_inc;
                state_next = ST_INS_RD;
            end
            ST_TCK_RD:
            begin
                if (pos_reg == cnt_reg)
                begin
                    if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        oid_next    = stq_pkg::ID_FIELD_W'(pend_reg);
                        olast_next  = 1'b1;
                        cnt_next    = cnt_reg - n_pos;
                        state_next  = ST_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_TCK_EV;
                end
            end
            ST_TCK_EV:
            begin
                if (pos_reg == n_pos && n_reg < stq_pkg::OUT_CNT_W'(stq_pkg::MAX_OUT)
                    && e_exp <= t_reg)
                begin
                    if (n_reg == '0 || out_free)
                    begin
                        if (n_reg != '0)
                        begin
                            ovalid_next = 1'b1;
                            oid_next    = stq_pkg::ID_FIELD_W'(pend_reg);
                            olast_next  = 1'b0;
                        end
                        pend_next         = e_id;
                        n_next            = n_reg + stq_pkg::OUT_CNT_W'(1);
                        queued_next[e_id] = 1'b0;
                        pos_next          = pos_inc;
                        state_next        = ST_TCK_RD;
                    end
                end
                else if (n_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ID_W'(pos_reg - n_pos);
                    pos_next   = pos_inc;
                    state_next = ST_TCK_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            queued_reg <= '0;
            id_reg     <= '0;
            t_reg      <= '0;
            add_reg    <= 1'b0;
            found_reg  <= 1'b0;
            ins_reg    <= 1'b0;
            carry_reg  <= '0;
            n_reg      <= '0;
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
            oid_reg    <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            queued_reg <= queued_next;
            id_reg     <= id_next;
            t_reg      <= t_next;
            add_reg    <= add_next;
            found_reg  <= found_next;
            ins_reg    <= ins_next;
            carry_reg  <= carry_next;
            n_reg      <= n_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
            oid_reg    <= oid_next;
            olast_reg  <= olast_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(stq_pkg::OUT_DATA_W - stq_pkg::ID_FIELD_W){1'b0}}, oid_reg};
    assign m_tlast  = olast_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(NUM_TIMERS))
        else $error("queued count exceeds capacity");

    a_cnt_flags: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> 32'($countones(queued_reg)) == 32'(cnt_reg))
        else $error("queued flags disagree with queued count");

    a_tick_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TCK_RD && pos_reg == cnt_reg && out_free) |=> m_tvalid && m_tlast)
        else $error("tick ended without a final word");

endmodule

// File: rtl/core/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted timer expiry queue. Directed and random
// add, delete and tick words are streamed in; a behavioral timer list predicts
// the expired ids, which are compared in order with the output stream.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NT = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        stq_pkg::kind_t kind;
        logic [3:0]     id;
        logic [63:0]    expiry;
        logic [63:0]    now;
    } timer_op_t;

    typedef struct packed {
        logic [3:0] id;
        logic       tlast;
    } expiry_evt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [stq_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [stq_pkg::KIND_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [stq_pkg::OUT_DATA_W-1:0] m_tdata;
    logic m_tlast;

    timer_op_t   pending_ops[$];
    expiry_evt_t expected_expiries[$];
    logic [3:0]  timer_order[$];
    logic [63:0] timer_due[NT];
    int errors = 0;
    int cycles = 0;
    int ops_sent = 0;
    int expiries_seen = 0;
    bit hold_off = 1'b0;
    bit in_taken = 1'b0;
    bit quiet_in = 1'b0;
    bit quiet_out = 1'b0;
    bit stim_done = 1'b0;

    sorted_timer_expiry_queue_unit #(.NUM_TIMERS(NT)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 clk = ~clk;

    function automatic int find_timer(logic [3:0] id);
        foreach (timer_order[i])
            if (timer_order[i] == id)
                return i;
        return -1;
    endfunction

    task automatic predict_expiries(timer_op_t op);
        int pos;
        int n;
        expiry_evt_t ev;
        pos = 0;
        n = 0;
        case (op.kind)
            stq_pkg::KIND_ADD, stq_pkg::KIND_DEL:
            begin
                pos = find_timer(op.id);
                if (pos >= 0)
                    timer_order.delete(pos);
                if (op.kind == stq_pkg::KIND_ADD)
                begin
                    pos = 0;
                    while (pos < timer_order.size() && timer_due[timer_order[pos]] <= op.expiry)
                        pos++;
                    timer_order.insert(pos, op.id);
                    timer_due[op.id] = op.expiry;
                end
            end
            stq_pkg::KIND_TICK:
            begin
                while (timer_order.size() > 0 && n < stq_pkg::MAX_OUT
                       && timer_due[timer_order[0]] <= op.now)
                begin
                    ev.id = timer_order.pop_front();
                    ev.tlast = 1'b0;
                    expected_expiries.push_back(ev);
                    n++;
                end
                if (n > 0)
                begin
                    ev = expected_expiries.pop_back();
                    ev.tlast = 1'b1;
                    expected_expiries.push_back(ev);
                end
            end
            default: ;
        endcase
    endtask

    function automatic timer_op_t make_op(stq_pkg::kind_t k, int id, logic [63:0] e,
                                          logic [63:0] n);
        timer_op_t op;
        op.kind = k;
        op.id = id[3:0];
        op.expiry = e;
        op.now = n;
        return op;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (pending_ops.size() > 0 && (quiet_in || $urandom_range(99) >= 10))
                begin
                    timer_op_t op;
                    op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= op.kind;
                    s_tdata <= {4'b0, op.now, op.expiry, op.id};
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (hold_off)
                m_tready <= 1'b0;
            else
                m_tready <= quiet_out || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        in_taken = rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            timer_op_t op;
            op.kind = stq_pkg::kind_t'(s_tuser);
            op.id = s_tdata[3:0];
            op.expiry = s_tdata[67:4];
            op.now = s_tdata[131:68];
            predict_expiries(op);
            ops_sent++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            expiries_seen++;
            if (expected_expiries.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected expiry id=%0d last=%0b", m_tdata[3:0], m_tlast);
            end
            else
            begin
                expiry_evt_t ev;
                ev = expected_expiries.pop_front();
                if (ev.id !== m_tdata[3:0] || ev.tlast !== m_tlast || m_tdata[7:4] !== 4'b0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected id=%0d last=%0b, got data=%h last=%0b",
                                 ev.id, ev.tlast, m_tdata, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Long stall on the output while input keeps coming.
    initial
    begin
        wait (ops_sent >= 20);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        logic [63:0] clock_ns;
        int r;
        int k;
        int slot;
        // Directed: field extremes, equal expiries, re-add, absent delete, unused kind.
        pending_ops.push_back(make_op(stq_pkg::KIND_TICK, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_ops.push_back(make_op(stq_pkg::KIND_ADD, 15, 64'hFFFF_FFFF_FFFF_FFFF, 0));
        pending_ops.push_back(make_op(stq_pkg::KIND_ADD, 0, 0, 0));
        pending_ops.push_back(make_op(stq_pkg::KIND_ADD, 3, 100, 0));
        pending_ops.push_back(make_op(stq_pkg::KIND_ADD, 5, 100, 0));
        pending_ops.push_back(make_op(stq_pkg::KIND_ADD, 7, 50, 0));
        pending_ops.push_back(make_op(stq_pkg::KIND_ADD, 3, 100, 0));
        pending_ops.push_back(make_op(stq_pkg::KIND_DEL, 9, 0, 0));
        pending_ops.push_back(make_op(stq_pkg::KIND_DEL, 7, 0, 0));
        pending_ops.push_back(make_op(stq_pkg::KIND_NONE, 4, 64'hFFFF_FFFF_FFFF_FFFF,
                                      64'hFFFF_FFFF_FFFF_FFFF));
        pending_ops.push_back(make_op(stq_pkg::KIND_TICK, 0, 0, 99));
        pending_ops.push_back(make_op(stq_pkg::KIND_TICK, 0, 0, 100));
        pending_ops.push_back(make_op(stq_pkg::KIND_TICK, 0, 0, 64'hFFFF_FFFF_FFFF_FFFE));
        for (int i = 0; i < NT; i++)
            pending_ops.push_back(make_op(stq_pkg::KIND_ADD, i, 64'd7, 0));
        pending_ops.push_back(make_op(stq_pkg::KIND_TICK, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));

        // Random: mostly time-ordered adds and ticks, with a share of raw noise.
        clock_ns = 1000;
        for (int i = 0; i < 400; i++)
        begin
            r = $urandom_range(99);
            slot = $urandom_range(NT - 1);
            if (r < 45)
                pending_ops.push_back(make_op(stq_pkg::KIND_ADD, slot,
                    (i % 13 == 0) ? rand64() : clock_ns + $urandom_range(60), rand64()));
            else if (r < 60)
                pending_ops.push_back(make_op(stq_pkg::KIND_DEL, slot, rand64(), rand64()));
            else if (r < 92)
            begin
                clock_ns += $urandom_range(25);
                pending_ops.push_back(make_op(stq_pkg::KIND_TICK, slot, rand64(),
                    (i % 17 == 0) ? rand64() : clock_ns));
            end
            else
            begin
                k = $urandom_range(3);
                pending_ops.push_back(make_op(stq_pkg::kind_t'(k), slot, rand64(), rand64()));
            end
        end
        pending_ops.push_back(make_op(stq_pkg::KIND_TICK, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        pending_ops.push_back(make_op(stq_pkg::KIND_TICK, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (ops_sent >= 150);
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        wait (ops_sent >= 250);
        quiet_in = 1'b0;
        quiet_out = 1'b0;

        wait (pending_ops.size() == 0 && !s_tvalid);
        wait (expected_expiries.size() == 0);
        repeat (200) @(posedge clk);
        $display("Sent %0d timer words; checked %0d expiry words in queue order.",
                 ops_sent, expiries_seen);
        if (errors == 0 && expected_expiries.size() == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/stq_pkg.sv
rtl/core/stq_ram.sv
rtl/core/sorted_timer_expiry_queue_unit.sv
tb/tb_top.sv
